// ===== design/qrp_pkg.sv =====
// ----------------------------------------------------------------------------
// qrp_pkg: shared types and constants
// Field widths, gain reset values, register map and saturation helper
// for the roll/pitch PID mixer.
// ----------------------------------------------------------------------------
package qrp_pkg;

	localparam int IN_W   = 16;
	localparam int GAIN_W = 16;
	localparam int ERR_W  = IN_W + 1;
	localparam int DIFF_W = ERR_W + 1;
	localparam int INT_W  = 32;
	localparam int P_W    = GAIN_W + 1 + ERR_W;
	localparam int I_W    = GAIN_W + 1 + INT_W;
	localparam int D_W    = GAIN_W + 1 + DIFF_W;
	localparam int ACC_W  = I_W + 1;
	localparam int SHIFT  = 16;
	localparam int POW_W  = ACC_W - SHIFT;
	localparam int MIX_W  = POW_W + 2;
	localparam int OUT_W  = 20;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [GAIN_W-1:0] KP_RESET = 16'd2560;
	localparam logic [GAIN_W-1:0] KI_RESET = 16'd256;
	localparam logic [GAIN_W-1:0] KD_RESET = 16'd2560;

	typedef enum logic [1:0] {
		REG_KP = 2'd0,
		REG_KI = 2'd1,
		REG_KD = 2'd2
	} qrp_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} qrp_gains_t;

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [MIX_W-1:0] v);
		logic signed [MIX_W-1:0] hi;
		logic signed [MIX_W-1:0] lo;
		hi = MIX_W'(2 ** (OUT_W - 1) - 1);
		lo = -MIX_W'(2 ** (OUT_W - 1));
		if (v > hi) begin
			return hi[OUT_W-1:0];
		end else if (v < lo) begin
			return lo[OUT_W-1:0];
		end
		return v[OUT_W-1:0];
	endfunction

endpackage

// ===== design/qrp_axis.sv =====
// ----------------------------------------------------------------------------
// qrp_axis: single-axis PID term
// Error, saturating integral, derivative difference and the weighted sum
// shifted down with floor rounding. Holds the axis state.
// ----------------------------------------------------------------------------
module qrp_axis
	import qrp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  qrp_gains_t               gains,
	input  logic signed [IN_W-1:0]   target,
	input  logic signed [IN_W-1:0]   measured,
	output logic signed [POW_W-1:0]  power
);

	logic signed [INT_W-1:0]  integral_q;
	logic signed [ERR_W-1:0]  prev_err_q;
	logic signed [ERR_W-1:0]  err;
	logic signed [INT_W:0]    int_sum;
	logic signed [INT_W-1:0]  int_next;
	logic signed [DIFF_W-1:0] diff;
	logic signed [P_W-1:0]    p_term;
	logic signed [I_W-1:0]    i_term;
	logic signed [D_W-1:0]    d_term;
	logic signed [ACC_W-1:0]  acc;

	assign err     = ERR_W'(target) - ERR_W'(measured);
	assign int_sum = (INT_W + 1)'(integral_q) + (INT_W + 1)'(err);

	always_comb begin
		if (int_sum[INT_W] != int_sum[INT_W-1]) begin
			int_next = {int_sum[INT_W], {(INT_W - 1){~int_sum[INT_W]}}};
		end else begin
			int_next = int_sum[INT_W-1:0];
		end
	end

	assign diff   = DIFF_W'(err) - DIFF_W'(prev_err_q);
	assign p_term = $signed({1'b0, gains.kp}) * err;
	assign i_term = $signed({1'b0, gains.ki}) * int_next;
	assign d_term = $signed({1'b0, gains.kd}) * diff;
	assign acc    = ACC_W'(p_term) + ACC_W'(i_term) + ACC_W'(d_term);
	assign power  = POW_W'(acc >>> SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_err_q <= '0;
		end else if (step) begin
			integral_q <= int_next;
			prev_err_q <= err;
		end
	end

endmodule

// ===== design/quad_roll_pitch_pid_mixer.sv =====
// ----------------------------------------------------------------------------
// quad_roll_pitch_pid_mixer: roll/pitch PID with X-frame motor mixer
// An accepted request passes the input register, then the result register,
//   on its way to out_valid; one request per cycle when the output is free.
// The integral and previous-error registers update on every step of each axis,
//   which sets that rate; a stalled output holds the input register.
// Reset clears both valids and the axis state; gains return to defaults.
// ----------------------------------------------------------------------------
module quad_roll_pitch_pid_mixer
	import qrp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [IN_W-1:0]          throttle,
	input  logic signed [IN_W-1:0]   roll_target,
	input  logic signed [IN_W-1:0]   pitch_target,
	input  logic signed [IN_W-1:0]   roll_angle,
	input  logic signed [IN_W-1:0]   pitch_angle,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [OUT_W-1:0]  front_left_power,
	output logic signed [OUT_W-1:0]  front_right_power,
	output logic signed [OUT_W-1:0]  back_left_power,
	output logic signed [OUT_W-1:0]  back_right_power
);

	qrp_gains_t              gains_q;
	qrp_reg_t                reg_sel;
	logic                    valid_s1;
	logic [IN_W-1:0]         throttle_s1;
	logic signed [IN_W-1:0]  roll_target_s1;
	logic signed [IN_W-1:0]  pitch_target_s1;
	logic signed [IN_W-1:0]  roll_angle_s1;
	logic signed [IN_W-1:0]  pitch_angle_s1;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] fl_q;
	logic signed [OUT_W-1:0] fr_q;
	logic signed [OUT_W-1:0] bl_q;
	logic signed [OUT_W-1:0] br_q;
	logic                    advance;
	logic                    step;
	logic                    accept;
	logic signed [POW_W-1:0] roll_pow;
	logic signed [POW_W-1:0] pitch_pow;
	logic signed [MIX_W-1:0] base;
	logic signed [MIX_W-1:0] roll_x;
	logic signed [MIX_W-1:0] pitch_x;

	assign pready  = 1'b1;
	assign reg_sel = qrp_reg_t'(paddr[ADDR_W-1:2]);

	always_comb begin
		unique case (reg_sel)
			REG_KP:  prdata = DATA_W'(gains_q.kp);
			REG_KI:  prdata = DATA_W'(gains_q.ki);
			REG_KD:  prdata = DATA_W'(gains_q.kd);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.kp <= KP_RESET;
			gains_q.ki <= KI_RESET;
			gains_q.kd <= KD_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_KP:  gains_q.kp <= pwdata[GAIN_W-1:0];
				REG_KI:  gains_q.ki <= pwdata[GAIN_W-1:0];
				REG_KD:  gains_q.kd <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			throttle_s1     <= throttle;
			roll_target_s1  <= roll_target;
			pitch_target_s1 <= pitch_target;
			roll_angle_s1   <= roll_angle;
			pitch_angle_s1  <= pitch_angle;
		end
	end

	qrp_axis u_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.gains    (gains_q),
		.target   (roll_target_s1),
		.measured (roll_angle_s1),
		.power    (roll_pow)
	);

	qrp_axis u_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.gains    (gains_q),
		.target   (pitch_target_s1),
		.measured (pitch_angle_s1),
		.power    (pitch_pow)
	);

	assign base    = $signed({{(MIX_W - IN_W){1'b0}}, throttle_s1});
	assign roll_x  = MIX_W'(roll_pow);
	assign pitch_x = MIX_W'(pitch_pow);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			fl_q <= sat_out(base - roll_x + pitch_x);
			fr_q <= sat_out(base + roll_x + pitch_x);
			bl_q <= sat_out(base - roll_x - pitch_x);
			br_q <= sat_out(base + roll_x - pitch_x);
		end
	end

	assign out_valid         = out_valid_q;
	assign front_left_power  = fl_q;
	assign front_right_power = fr_q;
	assign back_left_power   = bl_q;
	assign back_right_power  = br_q;

endmodule

// ===== design/qrp_checker.sv =====
// ----------------------------------------------------------------------------
// qrp_checker: port-level checks for the PID mixer
// Output hold under stall, stall cause and request latency, bound to the
// top level.
// ----------------------------------------------------------------------------
module qrp_checker
	import qrp_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [OUT_W-1:0]  front_left_power,
	input logic signed [OUT_W-1:0]  back_right_power
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(front_left_power) && $stable(back_right_power))
		else $error("stalled result changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("accepted request not delivered after two cycles");

endmodule

bind quad_roll_pitch_pid_mixer qrp_checker u_qrp_checker (.*);

// ===== tb/qrp_checker.sv =====
// ----------------------------------------------------------------------------
// qrp_scoreboard: motor power scoreboard for the roll/pitch PID mixer
// Watches the register port and both request channels, keeps its own copy
// of the gains and of the per-axis integral and last error, works out the
// four motor powers for every accepted request and compares each accepted
// result against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module qrp_scoreboard
	import qrp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic                    pready,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [IN_W-1:0]         throttle,
	input  logic signed [IN_W-1:0]  roll_target,
	input  logic signed [IN_W-1:0]  pitch_target,
	input  logic signed [IN_W-1:0]  roll_angle,
	input  logic signed [IN_W-1:0]  pitch_angle,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic signed [OUT_W-1:0] front_left_power,
	input  logic signed [OUT_W-1:0] front_right_power,
	input  logic signed [OUT_W-1:0] back_left_power,
	input  logic signed [OUT_W-1:0] back_right_power,
	output int                      fail_count,
	output int                      pending
);

	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -64'sd2147483648;
	localparam longint PWR_MAX = 64'sd524287;
	localparam longint PWR_MIN = -64'sd524288;

	typedef struct {
		logic signed [OUT_W-1:0] fl;
		logic signed [OUT_W-1:0] fr;
		logic signed [OUT_W-1:0] bl;
		logic signed [OUT_W-1:0] br;
	} motor_set_t;

	motor_set_t motor_q[$];

	longint kp_q;
	longint ki_q;
	longint kd_q;
	longint roll_sum;
	longint roll_last;
	longint pitch_sum;
	longint pitch_last;

	function automatic longint clamp_l(longint v, longint lo, longint hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// arithmetic shift of the signed sum floors toward minus infinity
	function automatic longint pid_effort(longint err, longint sum, longint last);
		longint acc;
		acc = kp_q * err + ki_q * sum + kd_q * (err - last);
		return acc >>> SHIFT;
	endfunction

	function automatic logic signed [OUT_W-1:0] motor_clip(longint v);
		longint c;
		c = clamp_l(v, PWR_MIN, PWR_MAX);
		return OUT_W'(c);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint roll_err;
		longint pitch_err;
		longint roll_eff;
		longint pitch_eff;
		longint thr;
		motor_set_t want;
		if (!arst_n) begin
			kp_q       = longint'(KP_RESET);
			ki_q       = longint'(KI_RESET);
			kd_q       = longint'(KD_RESET);
			roll_sum   = 0;
			roll_last  = 0;
			pitch_sum  = 0;
			pitch_last = 0;
			motor_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_KP: kp_q = longint'(pwdata[GAIN_W-1:0]);
					REG_KI: ki_q = longint'(pwdata[GAIN_W-1:0]);
					REG_KD: kd_q = longint'(pwdata[GAIN_W-1:0]);
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				if (motor_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected result fl=%0d fr=%0d bl=%0d br=%0d",
							front_left_power, front_right_power,
							back_left_power, back_right_power);
					end
				end else begin
					want = motor_q.pop_front();
					if (want.fl !== front_left_power || want.fr !== front_right_power ||
							want.bl !== back_left_power || want.br !== back_right_power) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch exp fl=%0d fr=%0d bl=%0d br=%0d got fl=%0d fr=%0d bl=%0d br=%0d",
								want.fl, want.fr, want.bl, want.br,
								front_left_power, front_right_power,
								back_left_power, back_right_power);
						end
					end
				end
			end

			if (in_valid && !in_stall) begin
				roll_err   = longint'(roll_target) - longint'(roll_angle);
				pitch_err  = longint'(pitch_target) - longint'(pitch_angle);
				roll_sum   = clamp_l(roll_sum + roll_err, SUM_MIN, SUM_MAX);
				pitch_sum  = clamp_l(pitch_sum + pitch_err, SUM_MIN, SUM_MAX);
				roll_eff   = pid_effort(roll_err, roll_sum, roll_last);
				pitch_eff  = pid_effort(pitch_err, pitch_sum, pitch_last);
				roll_last  = roll_err;
				pitch_last = pitch_err;
				thr        = longint'(throttle);
				want.fl    = motor_clip(thr - roll_eff + pitch_eff);
				want.fr    = motor_clip(thr + roll_eff + pitch_eff);
				want.bl    = motor_clip(thr - roll_eff - pitch_eff);
				want.br    = motor_clip(thr + roll_eff - pitch_eff);
				motor_q.push_back(want);
			end

			pending = motor_q.size();
		end
	end

endmodule

// ===== tb/tb_quad_roll_pitch_pid_mixer.sv =====
// ----------------------------------------------------------------------------
// tb_quad_roll_pitch_pid_mixer: stimulus and verdict for the PID mixer
// Drives gain settings through the register port between idle phases, a
// short directed set of extreme samples, random samples under random
// idling and a long receiver hold-off, then a steady run that winds both
// integrals one way and back. Checking lives in qrp_scoreboard.
// ----------------------------------------------------------------------------
module tb_quad_roll_pitch_pid_mixer;
	import qrp_pkg::*;

	localparam int         CYCLE_LIMIT = 20000;
	localparam logic [1:0] SPARE_IDX   = 2'd3;

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [DATA_W-1:0]       pwdata;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    in_valid;
	logic                    in_stall;
	logic [IN_W-1:0]         throttle;
	logic signed [IN_W-1:0]  roll_target;
	logic signed [IN_W-1:0]  pitch_target;
	logic signed [IN_W-1:0]  roll_angle;
	logic signed [IN_W-1:0]  pitch_angle;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [OUT_W-1:0] front_left_power;
	logic signed [OUT_W-1:0] front_right_power;
	logic signed [OUT_W-1:0] back_left_power;
	logic signed [OUT_W-1:0] back_right_power;

	int fail_count;
	int pending;
	int cycle_count;
	int hold_go;
	int hold_seen;
	int hold_left;
	bit quiet;

	quad_roll_pitch_pid_mixer dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.throttle          (throttle),
		.roll_target       (roll_target),
		.pitch_target      (pitch_target),
		.roll_angle        (roll_angle),
		.pitch_angle       (pitch_angle),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.front_left_power  (front_left_power),
		.front_right_power (front_right_power),
		.back_left_power   (back_left_power),
		.back_right_power  (back_right_power)
	);

	qrp_scoreboard motor_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.pready            (pready),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.throttle          (throttle),
		.roll_target       (roll_target),
		.pitch_target      (pitch_target),
		.roll_angle        (roll_angle),
		.pitch_angle       (pitch_angle),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.front_left_power  (front_left_power),
		.front_right_power (front_right_power),
		.back_left_power   (back_left_power),
		.back_right_power  (back_right_power),
		.fail_count        (fail_count),
		.pending           (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off whenever one is requested
	initial begin
		out_stall <= 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_seen != hold_go) begin
				hold_seen = hold_go;
				hold_left = 79;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 14);
			end
		end
	end

	function automatic logic [15:0] pick16();
		logic [15:0] v;
		case ($urandom_range(7))
			0: v = 16'h8000;
			1: v = 16'h7FFF;
			2: v = 16'h0000;
			3: v = 16'hFFFF;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [GAIN_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {16'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
			input logic [GAIN_W-1:0] kd);
		reg_write({REG_KP, 2'b00}, kp);
		reg_write({REG_KI, 2'b00}, ki);
		reg_write({REG_KD, 2'b00}, kd);
	endtask

	task automatic push_sample(input logic [15:0] thr, input logic [15:0] rt,
			input logic [15:0] pt, input logic [15:0] ra, input logic [15:0] pa);
		int gap;
		if (!quiet && $urandom_range(99) < 14) begin
			gap = $urandom_range(3, 1);
			repeat (gap) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid     <= 1'b1;
		throttle     <= thr;
		roll_target  <= rt;
		pitch_target <= pt;
		roll_angle   <= ra;
		pitch_angle  <= pa;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic rand_sample();
		logic [15:0] thr;
		logic [15:0] rt;
		logic [15:0] pt;
		logic [15:0] ra;
		logic [15:0] pa;
		thr = pick16();
		rt  = pick16();
		pt  = pick16();
		if ($urandom_range(1) == 1) begin
			ra = rt + 16'($urandom_range(511)) - 16'd256;
			pa = pt + 16'($urandom_range(511)) - 16'd256;
		end else begin
			ra = pick16();
			pa = pick16();
		end
		push_sample(thr, rt, pt, ra, pa);
	endtask

	task automatic random_run(input int count);
		for (int i = 0; i < count; i++) begin
			rand_sample();
		end
	endtask

	// drop valid and wait for the pipeline to drain before touching gains
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		quiet  = 1'b0;
		hold_go = 0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		in_valid     <= 1'b0;
		throttle     <= '0;
		roll_target  <= '0;
		pitch_target <= '0;
		roll_angle   <= '0;
		pitch_angle  <= '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default gains: zero, extremes, unit errors either side of zero
		push_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		push_sample(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		push_sample(16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		push_sample(16'h1234, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF);
		push_sample(16'h4321, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000);
		push_sample(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		push_sample(16'h0000, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF);
		drain();

		// largest gains: motors clip high and low, then random samples with a long receiver hold-off
		set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
		repeat (4) push_sample(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
		repeat (4) push_sample(16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
		repeat (4) push_sample(16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		random_run(10);
		hold_go++;
		random_run(60);
		drain();

		set_gains(16'h0000, 16'h0000, 16'h0000);
		random_run(50);
		drain();

		set_gains(16'($urandom), 16'($urandom), 16'($urandom));
		reg_write({SPARE_IDX, 2'b00}, 16'($urandom));
		quiet = 1'b1;
		random_run(80);
		quiet = 1'b0;
		drain();

		set_gains(16'($urandom), 16'($urandom_range(255)), 16'($urandom));
		random_run(70);
		drain();

		set_gains(16'($urandom), 16'h0000, 16'hFFFF);
		random_run(60);
		drain();

		// integral only: wind both sums one way, then back
		set_gains(16'h0000, 16'h0001, 16'h0000);
		for (int i = 0; i < 30; i++) begin
			push_sample(16'($urandom), 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		end
		for (int i = 0; i < 15; i++) begin
			push_sample(16'($urandom), 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		end
		random_run(30);

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/qrp_pkg.sv
design/qrp_axis.sv
design/quad_roll_pitch_pid_mixer.sv
design/qrp_checker.sv
tb/qrp_checker.sv
tb/tb_quad_roll_pitch_pid_mixer.sv
